FILE: hdl/kab_pkg.sv
package kab_pkg;

    // axis count and index width
    localparam int AXIS_COUNT = 2;
    localparam int AXIS_IW = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;

    // configuration register indexes
    localparam logic [1:0] CFG_NOISE_ANGLE = 2'd0;
    localparam logic [1:0] CFG_NOISE_BIAS  = 2'd1;
    localparam logic [1:0] CFG_NOISE_MEAS  = 2'd2;

    // configuration reset values (Q0.24)
    localparam logic [23:0] RST_NOISE_ANGLE = 24'd16777;
    localparam logic [23:0] RST_NOISE_BIAS  = 24'd50332;
    localparam logic [23:0] RST_NOISE_MEAS  = 24'd503316;

    // input commands
    localparam logic CMD_UPDATE    = 1'b0;
    localparam logic CMD_SET_ANGLE = 1'b1;

    // saturation bounds
    localparam logic signed [47:0] SAT_MAX = 48'sd2147483647;
    localparam logic signed [47:0] SAT_MIN = -48'sd2147483648;

    typedef struct packed {
        logic               command;
        logic               axis_select;
        logic signed [31:0] measured_angle;
        logic signed [31:0] gyro_rate;
        logic [23:0]        time_step;
    } t_in_item;

    typedef struct packed {
        logic               result_axis;
        logic signed [31:0] filtered_angle;
        logic signed [31:0] unbiased_rate;
    } t_out_item;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RATE,
        ST_MUL_DT_RATE,
        ST_MUL_DT_P11,
        ST_PROJ_T,
        ST_MUL_DT_T,
        ST_MUL_QB_DT,
        ST_INNOV_VAR,
        ST_DIV0_GO,
        ST_DIV0_WAIT,
        ST_DIV1_GO,
        ST_DIV1_WAIT,
        ST_INNOV,
        ST_MUL_K0_Y,
        ST_MUL_K1_Y,
        ST_MUL_K0_P00,
        ST_MUL_K0_P01,
        ST_MUL_K1_P00,
        ST_MUL_K1_P01,
        ST_WRITEBACK
    } t_state;

    // saturate to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX) begin
            r = 32'sh7fffffff;
        end else if (v < SAT_MIN) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // shift right by 24, round to nearest, ties away from zero
    function automatic logic signed [44:0] rnd24(input logic signed [67:0] v);
        logic [67:0] mag;
        logic [67:0] r;
        logic signed [44:0] res;
        mag = v[67] ? 68'(-v) : 68'(v);
        r   = (mag + 68'd8388608) >> 24;
        res = v[67] ? -$signed(r[44:0]) : $signed(r[44:0]);
        return res;
    endfunction

endpackage

FILE: hdl/kab_div.sv
// gain divider: sat32((num * 2^24) / den), den > 0, two quotient bits per cycle
module kab_div
    import kab_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_num,
    input  logic [31:0]        i_den,
    output logic               o_done,
    output logic signed [31:0] o_quot
);

    logic        r_busy;
    logic        r_fin;
    logic [3:0]  r_cnt;
    logic [32:0] r_rem;
    logic [31:0] r_lo;
    logic [31:0] r_q;
    logic [31:0] r_den;
    logic        r_neg;
    logic        r_sat;

    logic [31:0] w_mag;
    logic [32:0] w_rem1;
    logic [32:0] w_rem2;
    logic [32:0] w_sh1;
    logic [32:0] w_sh2;
    logic        w_q1;
    logic        w_q2;

    // magnitude of the dividend
    assign w_mag = i_num[31] ? 32'(-i_num) : 32'(i_num);

    // two restoring steps
    always_comb begin
        w_sh1 = {r_rem[31:0], r_lo[31]};
        w_q1  = (w_sh1 >= {1'b0, r_den});
        w_rem1 = w_q1 ? (w_sh1 - {1'b0, r_den}) : w_sh1;
        w_sh2 = {w_rem1[31:0], r_lo[30]};
        w_q2  = (w_sh2 >= {1'b0, r_den});
        w_rem2 = w_q2 ? (w_sh2 - {1'b0, r_den}) : w_sh2;
    end

    // iteration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_fin <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= {9'b0, w_mag[31:8]};
                r_lo   <= {w_mag[7:0], 24'b0};
                r_q    <= '0;
                r_den  <= i_den;
                r_neg  <= i_num[31];
                r_sat  <= ({8'b0, w_mag[31:8]} >= i_den);
            end else if (r_busy) begin
                r_rem <= w_rem2;
                r_lo  <= {r_lo[29:0], 2'b0};
                r_q   <= {r_q[29:0], w_q1, w_q2};
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    // sign and saturation of the quotient
    always_comb begin
        if (r_sat) begin
            o_quot = r_neg ? 32'sh80000000 : 32'sh7fffffff;
        end else if (r_neg) begin
            o_quot = (r_q > 32'h80000000) ? 32'sh80000000 : $signed(-r_q);
        end else begin
            o_quot = r_q[31] ? 32'sh7fffffff : $signed(r_q);
        end
    end

    assign o_done = r_fin;

endmodule

FILE: hdl/kalman_angle_bias_filter.sv
// two-state angle and gyro bias filter, one shared datapath for all axes
//
// input channel: i_in_valid / o_in_stall with a t_in_item payload. command 0
// runs one filter update on the selected axis, command 1 loads its angle.
// output channel: o_out_valid / i_out_stall with a t_out_item payload; every
// transaction on the input gives exactly one result transaction.
// config port: i_cfg_we writes i_cfg_data into the register i_cfg_index
// (angle noise, bias noise, measurement noise); write only while idle.
//
// update path: an update runs from acceptance to a valid result through
// one shared signed multiplier used ten times and a two-bit-per-cycle
// divider run twice for the gains, each divide with its start and hand-off.
// When the innovation variance is not positive the divides are skipped.
// A set-angle result is valid on the cycle after acceptance.
// throughput: one item at a time; the next is taken once the sequencer is
// idle and the output register is empty or being drained.
// reset: synchronous, active low; clears all axis state to zero and restores
// the default noise values. A stalled result is held in the output register
// and blocks new input transactions until it is taken.
module kalman_angle_bias_filter
    import kab_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    t_state r_state;
    t_state n_state;

    // configuration
    logic [23:0] r_noise_angle;
    logic [23:0] r_noise_bias;
    logic [23:0] r_noise_meas;

    // per-axis state
    logic signed [31:0] r_ang_st [AXIS_COUNT];
    logic signed [31:0] r_bias_st [AXIS_COUNT];
    logic signed [31:0] r_p00_st [AXIS_COUNT];
    logic signed [31:0] r_p01_st [AXIS_COUNT];
    logic signed [31:0] r_p10_st [AXIS_COUNT];
    logic signed [31:0] r_p11_st [AXIS_COUNT];

    // working registers
    logic [AXIS_IW-1:0] r_axis;
    logic signed [31:0] r_meas;
    logic signed [31:0] r_gyro;
    logic [23:0]        r_dt;
    logic signed [31:0] r_ang;
    logic signed [31:0] r_bias;
    logic signed [31:0] r_p00;
    logic signed [31:0] r_p01;
    logic signed [31:0] r_p10;
    logic signed [31:0] r_p11;
    logic signed [31:0] r_p00t;
    logic signed [31:0] r_p01t;
    logic signed [31:0] r_rate;
    logic signed [35:0] r_t;
    logic signed [31:0] r_k0;
    logic signed [31:0] r_k1;
    logic signed [31:0] r_y;
    logic signed [67:0] r_prod;

    // output register
    logic      r_out_valid;
    t_out_item r_out_data;

    logic               w_accept;
    logic               w_out_take;
    logic [AXIS_IW-1:0] w_axis;
    logic signed [35:0] n_mul_a;
    logic signed [31:0] n_mul_b;
    logic signed [44:0] w_rnd;
    logic signed [32:0] w_s;
    logic               w_div_start;
    logic signed [31:0] w_div_num;
    logic               w_div_done;
    logic signed [31:0] w_div_quot;

    // handshakes
    assign w_out_take = r_out_valid && !i_out_stall;
    assign o_in_stall = !i_rst_n || (r_state != ST_IDLE) || (r_out_valid && i_out_stall);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // clamp the axis index
    always_comb begin
        if ({31'b0, i_in_data.axis_select} >= 32'(AXIS_COUNT)) begin
            w_axis = AXIS_IW'(AXIS_COUNT - 1);
        end else begin
            w_axis = AXIS_IW'(i_in_data.axis_select);
        end
    end

    // rounded product of the previous multiply, innovation variance
    assign w_rnd = rnd24(r_prod);
    assign w_s   = 33'(r_p00) + $signed({9'b0, r_noise_meas});

    // shared multiplier operand select
    always_comb begin
        n_mul_a = '0;
        n_mul_b = '0;
        unique case (r_state)
            ST_MUL_DT_RATE: begin
                n_mul_a = 36'(r_rate);
                n_mul_b = $signed({8'b0, r_dt});
            end
            ST_MUL_DT_P11: begin
                n_mul_a = 36'(r_p11);
                n_mul_b = $signed({8'b0, r_dt});
            end
            ST_MUL_DT_T: begin
                n_mul_a = r_t;
                n_mul_b = $signed({8'b0, r_dt});
            end
            ST_MUL_QB_DT: begin
                n_mul_a = $signed({12'b0, r_noise_bias});
                n_mul_b = $signed({8'b0, r_dt});
            end
            ST_MUL_K0_Y: begin
                n_mul_a = 36'(r_y);
                n_mul_b = r_k0;
            end
            ST_MUL_K1_Y: begin
                n_mul_a = 36'(r_y);
                n_mul_b = r_k1;
            end
            ST_MUL_K0_P00: begin
                n_mul_a = 36'(r_p00t);
                n_mul_b = r_k0;
            end
            ST_MUL_K0_P01: begin
                n_mul_a = 36'(r_p01t);
                n_mul_b = r_k0;
            end
            ST_MUL_K1_P00: begin
                n_mul_a = 36'(r_p00t);
                n_mul_b = r_k1;
            end
            ST_MUL_K1_P01: begin
                n_mul_a = 36'(r_p01t);
                n_mul_b = r_k1;
            end
            default: begin
                n_mul_a = '0;
                n_mul_b = '0;
            end
        endcase
    end

    // divider control
    assign w_div_start = (r_state == ST_DIV0_GO) || (r_state == ST_DIV1_GO);
    assign w_div_num   = (r_state == ST_DIV0_GO) ? r_p00 : r_p10;

    kab_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_s[31:0]),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && i_in_data.command == CMD_UPDATE) begin
                    n_state = ST_RATE;
                end
            end
            ST_RATE:        n_state = ST_MUL_DT_RATE;
            ST_MUL_DT_RATE: n_state = ST_MUL_DT_P11;
            ST_MUL_DT_P11:  n_state = ST_PROJ_T;
            ST_PROJ_T:      n_state = ST_MUL_DT_T;
            ST_MUL_DT_T:    n_state = ST_MUL_QB_DT;
            ST_MUL_QB_DT:   n_state = ST_INNOV_VAR;
            ST_INNOV_VAR:   n_state = ST_DIV0_GO;
            ST_DIV0_GO: begin
                n_state = (w_s > 33'sd0) ? ST_DIV0_WAIT : ST_INNOV;
            end
            ST_DIV0_WAIT: begin
                if (w_div_done) begin
                    n_state = ST_DIV1_GO;
                end
            end
            ST_DIV1_GO:     n_state = ST_DIV1_WAIT;
            ST_DIV1_WAIT: begin
                if (w_div_done) begin
                    n_state = ST_INNOV;
                end
            end
            ST_INNOV:       n_state = ST_MUL_K0_Y;
            ST_MUL_K0_Y:    n_state = ST_MUL_K1_Y;
            ST_MUL_K1_Y:    n_state = ST_MUL_K0_P00;
            ST_MUL_K0_P00:  n_state = ST_MUL_K0_P01;
            ST_MUL_K0_P01:  n_state = ST_MUL_K1_P00;
            ST_MUL_K1_P00:  n_state = ST_MUL_K1_P01;
            ST_MUL_K1_P01:  n_state = ST_WRITEBACK;
            ST_WRITEBACK:   n_state = ST_IDLE;
            default:        n_state = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // shared multiplier, one product per cycle
    always_ff @(posedge i_clk) begin
        r_prod <= n_mul_a * n_mul_b;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_noise_angle <= RST_NOISE_ANGLE;
            r_noise_bias  <= RST_NOISE_BIAS;
            r_noise_meas  <= RST_NOISE_MEAS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_NOISE_ANGLE: r_noise_angle <= i_cfg_data;
                CFG_NOISE_BIAS:  r_noise_bias  <= i_cfg_data;
                CFG_NOISE_MEAS:  r_noise_meas  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // per-axis state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < AXIS_COUNT; i++) begin
                r_ang_st[i]  <= '0;
                r_bias_st[i] <= '0;
                r_p00_st[i]  <= '0;
                r_p01_st[i]  <= '0;
                r_p10_st[i]  <= '0;
                r_p11_st[i]  <= '0;
            end
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_take) begin
                r_out_valid <= 1'b0;
            end
            if (w_accept && i_in_data.command == CMD_SET_ANGLE) begin
                r_ang_st[w_axis] <= i_in_data.measured_angle;
                r_out_valid <= 1'b1;
                r_out_data.result_axis    <= 1'(w_axis);
                r_out_data.filtered_angle <= i_in_data.measured_angle;
                r_out_data.unbiased_rate  <= '0;
            end
            if (r_state == ST_WRITEBACK) begin
                r_ang_st[r_axis]  <= r_ang;
                r_bias_st[r_axis] <= r_bias;
                r_p00_st[r_axis]  <= r_p00;
                r_p01_st[r_axis]  <= r_p01;
                r_p10_st[r_axis]  <= r_p10;
                r_p11_st[r_axis]  <= sat32(48'(r_p11) - 48'(w_rnd));
                r_out_valid <= 1'b1;
                r_out_data.result_axis    <= 1'(r_axis);
                r_out_data.filtered_angle <= r_ang;
                r_out_data.unbiased_rate  <= r_rate;
            end
        end
    end

    // update datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    r_axis <= w_axis;
                    r_meas <= i_in_data.measured_angle;
                    r_gyro <= i_in_data.gyro_rate;
                    r_dt   <= i_in_data.time_step;
                    r_ang  <= r_ang_st[w_axis];
                    r_bias <= r_bias_st[w_axis];
                    r_p00  <= r_p00_st[w_axis];
                    r_p01  <= r_p01_st[w_axis];
                    r_p10  <= r_p10_st[w_axis];
                    r_p11  <= r_p11_st[w_axis];
                end
            end
            // bias-corrected rate
            ST_RATE: begin
                r_rate <= sat32(48'(r_gyro) - 48'(r_bias));
            end
            // predicted angle
            ST_MUL_DT_P11: begin
                r_ang <= sat32(48'(r_ang) + 48'(w_rnd));
            end
            // covariance projection terms using dt * p11
            ST_PROJ_T: begin
                r_t   <= 36'(w_rnd) - 36'(r_p01) - 36'(r_p10)
                         + $signed({12'b0, r_noise_angle});
                r_p01 <= sat32(48'(r_p01) - 48'(w_rnd));
                r_p10 <= sat32(48'(r_p10) - 48'(w_rnd));
            end
            ST_MUL_QB_DT: begin
                r_p00 <= sat32(48'(r_p00) + 48'(w_rnd));
            end
            ST_INNOV_VAR: begin
                r_p11 <= sat32(48'(r_p11) + 48'(w_rnd));
                r_k0  <= '0;
                r_k1  <= '0;
            end
            ST_DIV0_WAIT: begin
                if (w_div_done) begin
                    r_k0 <= w_div_quot;
                end
            end
            ST_DIV1_WAIT: begin
                if (w_div_done) begin
                    r_k1 <= w_div_quot;
                end
            end
            // innovation and covariance snapshot
            ST_INNOV: begin
                r_y    <= sat32(48'(r_meas) - 48'(r_ang));
                r_p00t <= r_p00;
                r_p01t <= r_p01;
            end
            // correction
            ST_MUL_K1_Y: begin
                r_ang <= sat32(48'(r_ang) + 48'(w_rnd));
            end
            ST_MUL_K0_P00: begin
                r_bias <= sat32(48'(r_bias) + 48'(w_rnd));
            end
            ST_MUL_K0_P01: begin
                r_p00 <= sat32(48'(r_p00) - 48'(w_rnd));
            end
            ST_MUL_K1_P00: begin
                r_p01 <= sat32(48'(r_p01) - 48'(w_rnd));
            end
            ST_MUL_K1_P01: begin
                r_p10 <= sat32(48'(r_p10) - 48'(w_rnd));
            end
            default: begin
            end
        endcase
    end

endmodule

FILE: hdl/kab_checker.sv
module kab_checker
    import kab_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input t_in_item    i_in_data,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input t_out_item   o_out_data,
    input logic        i_cfg_we,
    input logic [1:0]  i_cfg_index,
    input logic [23:0] i_cfg_data
);

    // a stalled result holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // no result survives reset
    assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // an accepted update raises the input stall
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_data.command == CMD_UPDATE |=> o_in_stall)
        else $error("input taken during update");

    // a set-angle transaction returns the loaded angle at once
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_data.command == CMD_SET_ANGLE
        |=> o_out_valid && o_out_data.unbiased_rate == 32'sd0
            && o_out_data.filtered_angle == $past(i_in_data.measured_angle))
        else $error("set-angle result wrong");

endmodule

bind kalman_angle_bias_filter kab_checker u_kab_checker (.*);
